// ===== src/xpfec_pkg.sv =====
// Shared types and constants of the XOR parity FEC encoder.
package xpfec_pkg;

   // Configuration register indexes
   typedef enum logic [0:0] {
      CSR_GROUP_SIZE = 1'b0,
      CSR_ROW_COUNT  = 1'b1
   } csr_index_type;

   // Beat kinds on the request channel (tuser)
   typedef enum logic [0:0] {
      OP_SOURCE = 1'b0,
      OP_READ   = 1'b1
   } op_type;

   localparam logic [7:0]  FEC_FIRST_BYTE     = 8'h40;
   localparam logic [4:0]  GROUP_SIZE_RESET   = 5'd5;
   localparam logic [7:0]  ROW_COUNT_RESET    = 8'd1;
   localparam logic [11:0] BYTE_POSITION_MAX  = 12'hFFF;
   localparam logic [11:0] REPAIR_FIXED_BYTES = 12'd12;
   localparam logic [11:0] SSRC_BYTES         = 12'd4;

   localparam int REQ_DATA_WIDTH = 128;
   localparam int RSP_DATA_WIDTH = 24;
   localparam int CSR_DATA_WIDTH = 8;

endpackage

// ===== src/xor_parity_fec_encoder_core.sv =====
// XOR parity FEC encoder: group accumulation in a parity RAM and repair readback.
// Request beats pass the second stage and output register to the response.
// Throughput: one beat per cycle unless the response stalls; each source byte is
// one parity RAM read-modify-write, read at acceptance, written back with bypass.
// Reset: synchronous, active high; clears counters, header parity, SSRC, valid
// flags; loads CSR defaults; the parity RAM and sequence list are not cleared.
module xor_parity_fec_encoder_core
   import xpfec_pkg::*;
#(
   parameter int MAX_PAYLOAD = 2048,
   parameter int MAX_GROUP   = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   // slave side
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // header_word[15:0], timestamp[47:16], sequence_number[63:48],
   // stream_id[95:64], payload_length[107:96], payload_byte[115:108],
   // read_index[127:116]
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   input  logic                      req_tlast,   // last_in_packet
   input  logic                      req_tuser,   // op
   // master side
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // group_complete[0], repair_length[12:1], read_byte[20:13],
   // index_error[21], zero[23:22]
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   // configuration
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int GW = $clog2(MAX_GROUP);

   // configuration
   logic [4:0]  group_size_ff;
   logic [7:0]  row_count_ff;

   // group state
   logic [63:0] header_parity_ff, header_parity_in;
   logic [15:0] sequence_list [MAX_GROUP];
   logic [4:0]  packet_count_ff, packet_count_in;
   logic [11:0] byte_position_ff, byte_position_in;
   logic [11:0] largest_payload_ff, largest_payload_in;
   logic [31:0] protected_ssrc_ff, protected_ssrc_in;
   logic [11:0] finished_length_ff, finished_length_in;

   // parity RAM
   logic [7:0]  parity_store [MAX_PAYLOAD];
   logic [7:0]  rd_data_ff;
   logic [AW-1:0] rd_addr;

   // request fields
   logic [15:0] f_header_word;
   logic [31:0] f_timestamp;
   logic [15:0] f_sequence_number;
   logic [31:0] f_stream_id;
   logic [11:0] f_payload_length;
   logic [7:0]  f_payload_byte;
   logic [11:0] f_read_index;

   // second stage
   logic          s1_valid_ff;
   logic          s1_wr_ff;
   logic          s1_xor_ff;
   logic [AW-1:0] s1_addr_ff;
   logic [7:0]    s1_pbyte_ff;
   logic          s1_use_mem_ff;
   logic [7:0]    s1_byte_ff;
   logic          s1_err_ff;
   logic          s1_done_ff;
   logic [11:0]   s1_len_ff;
   logic          fwd_hit_ff;
   logic [7:0]    fwd_data_ff;

   // output register
   logic          rsp_valid_ff;
   logic          rsp_done_ff;
   logic [11:0]   rsp_len_ff;
   logic [7:0]    rsp_byte_ff;
   logic          rsp_err_ff;

   logic          req_fire, rsp_adv, s1_adv, is_read;
   logic [4:0]    g_eff;
   logic [7:0]    seq_end;
   logic [7:0]    mem_byte, wr_byte;

   // source path
   logic          src_use, src_xor, group_done;
   logic [11:0]   clen, len_calc;
   logic [31:0]   bp_wide;
   logic [4:0]    count_next;
   logic [31:0]   count_wide;

   // read path
   logic          rd_err, rd_use_mem;
   logic [7:0]    rd_byte;
   logic [11:0]   rel, off;
   logic [31:0]   off_wide, ent_wide;
   logic [2:0]    hp_sel;
   logic [1:0]    ssrc_sel;
   logic [15:0]   seq_entry;

   assign f_header_word     = req_tdata[15:0];
   assign f_timestamp       = req_tdata[47:16];
   assign f_sequence_number = req_tdata[63:48];
   assign f_stream_id       = req_tdata[95:64];
   assign f_payload_length  = req_tdata[107:96];
   assign f_payload_byte    = req_tdata[115:108];
   assign f_read_index      = req_tdata[127:116];

   assign is_read    = (req_tuser == OP_READ);
   assign rsp_adv    = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && rsp_adv;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      if (group_size_ff == 5'd0) begin
         g_eff = 5'd1;
      end else if (32'(group_size_ff) > MAX_GROUP) begin
         g_eff = 5'(MAX_GROUP);
      end else begin
         g_eff = group_size_ff;
      end
   end

   assign seq_end = 8'd12 + {1'b0, g_eff, 2'b00};

   // ---------------- source beat: state update ----------------
   always_comb begin
      bp_wide    = 32'(byte_position_ff);
      src_use    = (byte_position_ff < f_payload_length) && (bp_wide < MAX_PAYLOAD);
      src_xor    = (byte_position_ff < largest_payload_ff);
      clen       = (32'(f_payload_length) < MAX_PAYLOAD) ? f_payload_length
                                                          : 12'(MAX_PAYLOAD);
      count_next = packet_count_ff + 5'd1;
      count_wide = 32'(packet_count_ff);

      header_parity_in   = header_parity_ff;
      protected_ssrc_in  = protected_ssrc_ff;
      largest_payload_in = largest_payload_ff;
      packet_count_in    = packet_count_ff;
      byte_position_in   = byte_position_ff;
      finished_length_in = 12'd0;
      group_done         = 1'b0;
      len_calc           = 12'd0;

      if (req_tlast) begin
         if (packet_count_ff == 5'd0) begin
            protected_ssrc_in = f_stream_id;
            header_parity_in  = {FEC_FIRST_BYTE, 56'd0};
         end
         header_parity_in = header_parity_in ^
            {2'b00, f_header_word[13:0], 4'b0000, f_payload_length, f_timestamp};
         if (clen > largest_payload_ff) begin
            largest_payload_in = clen;
         end
         len_calc = REPAIR_FIXED_BYTES + {5'd0, g_eff, 2'b00} + largest_payload_in;
         if (count_next >= g_eff) begin
            group_done         = 1'b1;
            finished_length_in = len_calc;
            packet_count_in    = 5'd0;
            largest_payload_in = 12'd0;
         end else begin
            packet_count_in = count_next;
         end
         byte_position_in = 12'd0;
      end else if (byte_position_ff != BYTE_POSITION_MAX) begin
         byte_position_in = byte_position_ff + 12'd1;
      end
   end

   // ---------------- read beat: repair byte ----------------
   always_comb begin
      rd_err     = (f_read_index >= finished_length_ff);
      rel        = f_read_index - REPAIR_FIXED_BYTES;
      off        = f_read_index - {4'd0, seq_end};
      off_wide   = 32'(off);
      ent_wide   = 32'(rel) >> 2;
      hp_sel     = 3'(4'd11 - f_read_index[3:0]);
      ssrc_sel   = 2'd3 - f_read_index[1:0];
      seq_entry  = sequence_list[ent_wide[GW-1:0]];
      rd_use_mem = 1'b0;
      rd_byte    = 8'd0;
      if (f_read_index < SSRC_BYTES) begin
         rd_byte = protected_ssrc_ff[{ssrc_sel, 3'b000} +: 8];
      end else if (f_read_index < REPAIR_FIXED_BYTES) begin
         rd_byte = header_parity_ff[{hp_sel, 3'b000} +: 8];
      end else if (f_read_index < {4'd0, seq_end}) begin
         case (rel[1:0])
            2'd0:    rd_byte = seq_entry[15:8];
            2'd1:    rd_byte = seq_entry[7:0];
            2'd2:    rd_byte = {3'd0, g_eff};
            default: rd_byte = row_count_ff;
         endcase
      end else if (off_wide < MAX_PAYLOAD) begin
         rd_use_mem = 1'b1;
      end
      if (rd_err) begin
         rd_use_mem = 1'b0;
         rd_byte    = 8'd0;
      end
   end

   assign rd_addr = is_read ? off_wide[AW-1:0] : bp_wide[AW-1:0];

   // ---------------- parity RAM ----------------
   assign mem_byte = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
   assign wr_byte  = s1_xor_ff ? (mem_byte ^ s1_pbyte_ff) : s1_pbyte_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_data_ff <= parity_store[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_wr_ff) begin
         parity_store[s1_addr_ff] <= wr_byte;
      end
   end

   // ---------------- sequence list ----------------
   always_ff @(posedge clock) begin
      if (req_fire && !is_read && req_tlast) begin
         sequence_list[count_wide[GW-1:0]] <= f_sequence_number;
      end
   end

   // ---------------- configuration and group state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff      <= GROUP_SIZE_RESET;
         row_count_ff       <= ROW_COUNT_RESET;
         header_parity_ff   <= 64'd0;
         packet_count_ff    <= 5'd0;
         byte_position_ff   <= 12'd0;
         largest_payload_ff <= 12'd0;
         protected_ssrc_ff  <= 32'd0;
         finished_length_ff <= 12'd0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_GROUP_SIZE: group_size_ff <= csr_wdata[4:0];
               CSR_ROW_COUNT:  row_count_ff  <= csr_wdata;
               default:        row_count_ff  <= row_count_ff;
            endcase
         end
         if (req_fire && !is_read) begin
            header_parity_ff   <= header_parity_in;
            packet_count_ff    <= packet_count_in;
            byte_position_ff   <= byte_position_in;
            largest_payload_ff <= largest_payload_in;
            protected_ssrc_ff  <= protected_ssrc_in;
            finished_length_ff <= finished_length_in;
         end
      end
   end

   // ---------------- second stage ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_wr_ff    <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
         s1_wr_ff    <= !is_read && src_use;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
         s1_wr_ff    <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_xor_ff     <= src_xor;
         s1_addr_ff    <= rd_addr;
         s1_pbyte_ff   <= f_payload_byte;
         s1_use_mem_ff <= is_read && rd_use_mem;
         s1_byte_ff    <= is_read ? rd_byte : 8'd0;
         s1_err_ff     <= is_read && rd_err;
         s1_done_ff    <= !is_read && group_done;
         s1_len_ff     <= is_read ? finished_length_ff : finished_length_in;
         // bypass the write that lands on the same edge as this read
         fwd_hit_ff    <= s1_adv && s1_wr_ff && (s1_addr_ff == rd_addr);
         fwd_data_ff   <= wr_byte;
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_done_ff <= s1_done_ff;
         rsp_len_ff  <= s1_len_ff;
         rsp_byte_ff <= s1_use_mem_ff ? mem_byte : s1_byte_ff;
         rsp_err_ff  <= s1_err_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_err_ff, rsp_byte_ff, rsp_len_ff, rsp_done_ff};

`ifndef SYNTHESIS
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("request side stalled without a blocked response");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_byte_ff == 8'd0 && !rsp_done_ff))
      else $error("index error beat carries data or completion");

   a_done_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> (rsp_len_ff >= 12'd16))
      else $error("completed group with impossible repair length");

   a_fwd_only_read: assert property (@(posedge clock) disable iff (reset)
      (req_fire && s1_adv && s1_wr_ff && s1_addr_ff == rd_addr) |=> fwd_hit_ff)
      else $error("same-entry access not bypassed");
`endif

endmodule

// ===== sim/xor_parity_fec_encoder_core_tb.sv =====
// Self-checking testbench for the XOR parity FEC encoder core.
`timescale 1ns / 1ps

module xor_parity_fec_encoder_core_tb;
   import xpfec_pkg::*;

   localparam int PAYLOAD_CAP      = 2048;
   localparam int GROUP_CAP        = 16;
   localparam int LONG_HOLD_CYCLES = 200;

   typedef struct packed {
      op_type      op;
      logic        last;
      logic [15:0] header_word;
      logic [31:0] timestamp;
      logic [15:0] seq_num;
      logic [31:0] ssrc;
      logic [11:0] payload_len;
      logic [7:0]  payload_byte;
      logic [11:0] read_index;
   } fec_req_type;

   typedef struct packed {
      logic        group_complete;
      logic [11:0] repair_length;
      logic [7:0]  read_byte;
      logic        index_error;
   } fec_rsp_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // header_word, timestamp, sequence_number, stream_id, payload_length,
   // payload_byte, read_index
   logic [REQ_DATA_WIDTH-1:0] req_tdata  = '0;
   logic                      req_tlast  = 1'b0;   // last_in_packet
   logic                      req_tuser  = 1'b0;   // op
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // group_complete, repair_length, read_byte, index_error, zero pad
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      csr_we     = 1'b0;
   csr_index_type             csr_index  = CSR_GROUP_SIZE;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata  = '0;

   // Encoder image kept alongside the block
   logic [7:0]  par_ram [PAYLOAD_CAP];
   bit          par_set [PAYLOAD_CAP];
   logic [15:0] seq_mem [GROUP_CAP];
   bit          seq_set [GROUP_CAP];
   logic [63:0] hdr_xor;
   logic [4:0]  pkt_cnt;
   logic [11:0] byte_pos;
   logic [11:0] max_len;
   logic [31:0] grp_ssrc;
   logic [11:0] repair_len;
   logic [4:0]  cfg_group;
   logic [7:0]  cfg_rows;

   fec_rsp_type encoder_rsp_q [$];
   int       error_count   = 0;
   int       beats_sent    = 0;
   int       send_idle_pct = 0;
   int       recv_idle_pct = 0;
   bit       hold_toggle   = 1'b0;

   xor_parity_fec_encoder_core #(
      .MAX_PAYLOAD(PAYLOAD_CAP),
      .MAX_GROUP  (GROUP_CAP)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #(2_000_000);
      $display("FAILURE");
      $finish;
   end

   function automatic logic [4:0] group_eff();
      if (cfg_group == 5'd0) return 5'd1;
      if (cfg_group > 5'(GROUP_CAP)) return 5'(GROUP_CAP);
      return cfg_group;
   endfunction

   function automatic logic [7:0] repair_byte_at(input logic [11:0] idx);
      int i, seq_end, e, p;
      logic [4:0] g;
      i = idx;
      g = group_eff();
      seq_end = 12 + 4 * g;
      if (i < 4) return grp_ssrc[8 * (3 - i) +: 8];
      if (i < 12) return hdr_xor[8 * (11 - i) +: 8];
      if (i < seq_end) begin
         e = (i - 12) / 4;
         case ((i - 12) % 4)
            0: return seq_mem[e % GROUP_CAP][15:8];
            1: return seq_mem[e % GROUP_CAP][7:0];
            2: return {3'b000, g};
            default: return cfg_rows;
         endcase
      end
      p = i - seq_end;
      if (p < PAYLOAD_CAP) return par_ram[p];
      return 8'h00;
   endfunction

   // True unless the read would land on a store entry never written
   function automatic bit read_defined(input logic [11:0] idx);
      int i, seq_end, p;
      i = idx;
      seq_end = 12 + 4 * group_eff();
      if (i >= repair_len || i < 12) return 1'b1;
      if (i < seq_end) return ((i - 12) % 4 >= 2) || seq_set[((i - 12) / 4) % GROUP_CAP];
      p = i - seq_end;
      return (p >= PAYLOAD_CAP) || par_set[p];
   endfunction

   function automatic fec_rsp_type encode_beat(input fec_req_type b);
      fec_rsp_type r;
      logic [4:0] g;
      logic [11:0] clen;
      r = '0;
      if (b.op == OP_READ) begin
         r.repair_length = repair_len;
         if (b.read_index >= repair_len) r.index_error = 1'b1;
         else r.read_byte = repair_byte_at(b.read_index);
         return r;
      end
      repair_len = '0;
      if (byte_pos < b.payload_len && byte_pos < PAYLOAD_CAP) begin
         if (byte_pos < max_len) begin
            par_ram[byte_pos] ^= b.payload_byte;
         end else begin
            par_ram[byte_pos] = b.payload_byte;
            par_set[byte_pos] = 1'b1;
         end
      end
      if (b.last) begin
         g = group_eff();
         clen = (b.payload_len < PAYLOAD_CAP) ? b.payload_len : 12'(PAYLOAD_CAP);
         if (pkt_cnt == 5'd0) begin
            grp_ssrc = b.ssrc;
            hdr_xor = {FEC_FIRST_BYTE, 56'd0};
         end
         hdr_xor ^= {2'b00, b.header_word[13:0], 4'h0, b.payload_len, b.timestamp};
         if (clen > max_len) max_len = clen;
         seq_mem[pkt_cnt[3:0]] = b.seq_num;
         seq_set[pkt_cnt[3:0]] = 1'b1;
         pkt_cnt++;
         if (pkt_cnt >= g) begin
            repair_len = REPAIR_FIXED_BYTES + {5'd0, g, 2'b00} + max_len;
            pkt_cnt = '0;
            max_len = '0;
            r.group_complete = 1'b1;
         end
         byte_pos = '0;
      end else if (byte_pos < BYTE_POSITION_MAX) begin
         byte_pos++;
      end
      r.repair_length = repair_len;
      return r;
   endfunction

   function automatic fec_req_type rand_packet(input logic [11:0] plen);
      fec_req_type b;
      b.op           = OP_SOURCE;
      b.last         = 1'b0;
      b.header_word  = 16'($urandom);
      b.timestamp    = $urandom;
      b.seq_num      = 16'($urandom);
      b.ssrc         = $urandom;
      b.payload_len  = plen;
      b.payload_byte = 8'($urandom);
      b.read_index   = 12'($urandom);
      return b;
   endfunction

   function automatic logic [11:0] pick_read_index();
      logic [11:0] idx;
      if (repair_len != 0 && $urandom_range(99) < 80) idx = 12'($urandom_range(repair_len));
      else idx = 12'($urandom_range(4095));
      if (!read_defined(idx)) idx = 12'($urandom_range(11));
      return idx;
   endfunction

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("%s", msg);
   endtask

   task automatic send_beat(input fec_req_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b.read_index, b.payload_byte, b.payload_len, b.ssrc,
                     b.seq_num, b.timestamp, b.header_word};
      req_tlast  <= b.last;
      req_tuser  <= b.op;
      do @(posedge clock); while (req_tready !== 1'b1);
      encoder_rsp_q.push_back(encode_beat(b));
      beats_sent++;
   endtask

   task automatic send_packet(input fec_req_type t, input int n_items, input bit jitter);
      fec_req_type b;
      int i;
      for (i = 0; i < n_items; i++) begin
         b = jitter ? rand_packet(12'($urandom_range(12))) : t;
         b.last = (i == n_items - 1);
         b.payload_byte = 8'($urandom);
         b.read_index = 12'($urandom);
         send_beat(b);
      end
   endtask

   task automatic send_read(input logic [11:0] idx);
      fec_req_type b;
      b = rand_packet(12'($urandom));
      b.op = OP_READ;
      b.last = 1'($urandom);
      b.read_index = idx;
      send_beat(b);
   endtask

   // Hold the sender until every outstanding response has drained
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (encoder_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == CSR_GROUP_SIZE) cfg_group = value[4:0];
      else cfg_rows = value;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_read_after_reset();
      send_read(12'd0);
      send_read(12'hFFF);
   endtask

   task automatic test_zero_length_group();
      fec_req_type t;
      int i;
      wait_drained();
      write_csr(CSR_GROUP_SIZE, 8'd1);
      write_csr(CSR_ROW_COUNT, 8'd0);
      t = rand_packet(12'd0);
      t.header_word = 16'hFFFF;
      t.timestamp   = 32'hFFFF_FFFF;
      t.seq_num     = 16'hFFFF;
      t.ssrc        = 32'hFFFF_FFFF;
      send_packet(t, 1, 1'b0);
      for (i = 0; i < 9; i++) send_read(12'(i * 2));
   endtask

   // Group size of zero clamps to one; then relayout after a register change
   task automatic test_layout_and_reconfig();
      wait_drained();
      write_csr(CSR_GROUP_SIZE, 8'd0);
      write_csr(CSR_ROW_COUNT, 8'd255);
      send_packet(rand_packet(12'd3), 3, 1'b0);
      send_read(12'd16);
      send_read(12'd17);
      send_read(12'd18);
      send_read(12'd19);
      wait_drained();
      write_csr(CSR_GROUP_SIZE, 8'd31);
      write_csr(CSR_ROW_COUNT, 8'hA5);
      send_read(12'd14);
      send_read(12'd15);
      send_read(12'd18);
   endtask

   // Shrink the group below the packets already taken: next packet end closes it
   task automatic test_group_shrink();
      wait_drained();
      write_csr(CSR_GROUP_SIZE, 8'd3);
      send_packet(rand_packet(12'd2), 2, 1'b0);
      send_packet(rand_packet(12'd0), 1, 1'b0);
      wait_drained();
      write_csr(CSR_GROUP_SIZE, 8'd1);
      send_packet(rand_packet(12'd1), 1, 1'b0);
      send_read(12'd12);
      send_read(12'd13);
      send_read(12'd16);
      send_read(12'd17);
   endtask

   // Stated length beyond the parity store: payload length clamps to the store size
   task automatic test_long_packet();
      wait_drained();
      write_csr(CSR_GROUP_SIZE, 8'd1);
      write_csr(CSR_ROW_COUNT, 8'd7);
      send_packet(rand_packet(12'hFFF), 120, 1'b0);
      send_read(12'd135);
      send_read(12'd2064);
      send_read(12'd17);
   endtask

   task automatic test_backpressure();
      int saved_pct, i;
      saved_pct = send_idle_pct;
      wait_drained();
      send_idle_pct = 0;
      hold_toggle = ~hold_toggle;
      for (i = 0; i < 6; i++) send_packet(rand_packet(12'd9), 9, 1'b0);
      wait_drained();
      send_idle_pct = saved_pct;
   endtask

   task automatic apply_random_settings();
      logic [7:0] gval, rval;
      case ($urandom_range(5))
         0: gval = 8'd0;
         1: gval = 8'd1;
         2: gval = 8'd16;
         3: gval = 8'd31;
         4: gval = {3'($urandom), 5'($urandom_range(2, 6))};
         default: gval = 8'($urandom_range(1, 16));
      endcase
      case ($urandom_range(3))
         0: rval = 8'd0;
         1: rval = 8'd255;
         default: rval = 8'($urandom);
      endcase
      write_csr(CSR_GROUP_SIZE, gval);
      write_csr(CSR_ROW_COUNT, rval);
   endtask

   task automatic send_random_unit();
      int pick, n, plen;
      bit jitter;
      fec_req_type t;
      pick = $urandom_range(99);
      jitter = 1'b0;
      if (pick < 10) begin
         send_read(pick_read_index());
      end else begin
         if (pick < 65) begin
            plen = $urandom_range(16);
            n = (plen == 0) ? 1 : plen;
         end else if (pick < 80) begin
            plen = $urandom_range(12);
            n = $urandom_range(1, plen + 4);
         end else if (pick < 92) begin
            plen = $urandom_range(4095);
            n = $urandom_range(1, 6);
         end else begin
            plen = $urandom_range(8);
            n = $urandom_range(1, 10);
            jitter = 1'b1;
         end
         t = rand_packet(12'(plen));
         send_packet(t, n, jitter);
         if (repair_len != 0 && $urandom_range(99) < 75) begin
            repeat ($urandom_range(1, 10)) send_read(pick_read_index());
         end
      end
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_beats);
      int stop_at, setting_end;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      stop_at = beats_sent + n_beats;
      while (beats_sent < stop_at) begin
         wait_drained();
         apply_random_settings();
         setting_end = beats_sent + 110;
         while (beats_sent < setting_end && beats_sent < stop_at) send_random_unit();
      end
   endtask

   // Response sink: random stalls plus a long hold-off on request
   initial begin : rsp_sink
      int hold_left;
      bit seen_toggle;
      hold_left = 0;
      seen_toggle = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_toggle != seen_toggle) begin
            seen_toggle = hold_toggle;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      fec_rsp_type got, want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got.group_complete = rsp_tdata[0];
         got.repair_length  = rsp_tdata[12:1];
         got.read_byte      = rsp_tdata[20:13];
         got.index_error    = rsp_tdata[21];
         if (encoder_rsp_q.size() == 0) begin
            flag_error($sformatf("unexpected rsp beat: gc=%0d len=%0d byte=%02h err=%0d",
               got.group_complete, got.repair_length, got.read_byte, got.index_error));
         end else begin
            want = encoder_rsp_q.pop_front();
            if (got !== want) begin
               flag_error($sformatf({"rsp mismatch: expected gc=%0d len=%0d byte=%02h ",
                  "err=%0d, got gc=%0d len=%0d byte=%02h err=%0d"},
                  want.group_complete, want.repair_length, want.read_byte,
                  want.index_error, got.group_complete, got.repair_length,
                  got.read_byte, got.index_error));
            end
         end
      end
   end

   initial begin : stimulus
      int k;
      for (k = 0; k < PAYLOAD_CAP; k++) begin
         par_ram[k] = '0;
         par_set[k] = 1'b0;
      end
      for (k = 0; k < GROUP_CAP; k++) begin
         seq_mem[k] = '0;
         seq_set[k] = 1'b0;
      end
      hdr_xor    = '0;
      pkt_cnt    = '0;
      byte_pos   = '0;
      max_len    = '0;
      grp_ssrc   = '0;
      repair_len = '0;
      cfg_group  = GROUP_SIZE_RESET;
      cfg_rows   = ROW_COUNT_RESET;
      send_idle_pct = 38;
      recv_idle_pct = 64;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_read_after_reset();
      test_zero_length_group();
      test_layout_and_reconfig();
      test_group_shrink();
      test_long_packet();
      test_backpressure();
      test_random_traffic(38, 64, 250);
      test_random_traffic(64, 38, 250);
      test_random_traffic(0, 0, 240);

      req_tvalid <= 1'b0;
      for (k = 0; k < 50000 && encoder_rsp_q.size() != 0; k++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (encoder_rsp_q.size() != 0) begin
         flag_error($sformatf("%0d rsp beats never arrived", encoder_rsp_q.size()));
      end
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/xpfec_pkg.sv
src/xor_parity_fec_encoder_core.sv
sim/xor_parity_fec_encoder_core_tb.sv
